>>> rtl/obpc_pkg.sv
// ----------------------------------------------------------------------------
// obpc_pkg
// Types and constants shared by the oriented box pair collision unit.
// ----------------------------------------------------------------------------
`default_nettype none

package obpc_pkg;

  // Angle resolution: only the top ANGLE_BITS bits of an angle are used.
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = ANGLE_BITS - 2;
  localparam int X_SHIFT    = 18 - ANGLE_BITS;

  // Quarter-wave sine polynomial coefficients, Q16.
  localparam int SIN_A       = 102944;
  localparam int SIN_B       = 42047;
  localparam int SIN_C       = 4640;
  localparam int QUARTER_Q16 = 65536;

  // Register stages from the input register to the output register.
  localparam int NSTG = 10;

  typedef struct packed {
    logic signed [23:0] a_pos_x;
    logic signed [23:0] a_pos_y;
    logic        [15:0] a_angle;
    logic        [15:0] a_radius;
    logic        [15:0] a_half_w;
    logic        [15:0] a_half_h;
    logic signed [23:0] b_pos_x;
    logic signed [23:0] b_pos_y;
    logic        [15:0] b_angle;
    logic        [15:0] b_radius;
    logic        [15:0] b_half_w;
    logic        [15:0] b_half_h;
  } obpc_in_t;

  typedef struct packed {
    logic collided;
    logic circle_hit;
    logic corner_hit;
  } obpc_out_t;

  // Values that travel alongside the sine pipeline.
  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic        [15:0] ahw;
    logic        [15:0] ahh;
    logic        [15:0] bhw;
    logic        [15:0] bhh;
    logic               circ;
  } obpc_carry_t;

endpackage

`default_nettype wire

>>> rtl/obpc_sine.sv
// ----------------------------------------------------------------------------
// obpc_sine
// Five-stage pipelined sine or cosine of an angle in turns, Q16 result.
// ----------------------------------------------------------------------------
`default_nettype none

module obpc_sine (
  input  wire logic               clk,
  input  wire logic [4:0]         en,
  input  wire logic [15:0]        ang,
  input  wire logic               cos_sel,
  output logic signed [17:0]      s
);
  import obpc_pkg::*;

  logic [ANGLE_BITS-1:0] phase;
  logic [1:0]            quad;
  logic [16:0]           x0;
  logic [16:0]           xa_nxt;

  logic [16:0] xa_r, xb_r, xc_r, xd_r;
  logic        na_r, nb_r, nc_r, nd_r;
  logic [16:0] x2b_r, x2c_r;
  logic [16:0] t1c_r;
  logic [16:0] t2d_r;
  logic signed [17:0] s_r;

  logic [33:0] sq_prod;
  logic [31:0] c_prod;
  logic [33:0] t_prod;
  logic [33:0] s_prod;
  logic [16:0] x2_nxt, t1_nxt, t2_nxt, mag;

  always_comb begin
    phase = ang[15 -: ANGLE_BITS];
    quad  = phase[ANGLE_BITS-1 -: 2] + {1'b0, cos_sel};
    x0    = 17'(phase[FRAC_BITS-1:0]) << X_SHIFT;
    xa_nxt = quad[0] ? (17'(QUARTER_Q16) - x0) : x0;
    sq_prod = 34'(xa_r) * 34'(xa_r);
    x2_nxt  = sq_prod[32:16];
    c_prod  = 32'(x2b_r) * 32'(SIN_C);
    t1_nxt  = 17'(SIN_B) - c_prod[32-1:16];
    t_prod  = 34'(x2c_r) * 34'(t1c_r);
    t2_nxt  = 17'(SIN_A) - t_prod[32:16];
    s_prod  = 34'(xd_r) * 34'(t2d_r);
    mag     = s_prod[32:16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xa_r <= xa_nxt;
      na_r <= quad[1];
    end
    if (en[1]) begin
      xb_r  <= xa_r;
      nb_r  <= na_r;
      x2b_r <= x2_nxt;
    end
    if (en[2]) begin
      xc_r  <= xb_r;
      nc_r  <= nb_r;
      x2c_r <= x2b_r;
      t1c_r <= t1_nxt;
    end
    if (en[3]) begin
      xd_r  <= xc_r;
      nd_r  <= nc_r;
      t2d_r <= t2_nxt;
    end
    if (en[4]) begin
      s_r <= nd_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign s = s_r;

endmodule

`default_nettype wire

>>> rtl/obpc_geom.sv
// ----------------------------------------------------------------------------
// obpc_geom
// Four-stage corner projection: rotation products, corner sums, box limits.
// ----------------------------------------------------------------------------
`default_nettype none

module obpc_geom (
  input  wire logic                  clk,
  input  wire logic [3:0]            en,
  input  wire logic signed [17:0]    sin_a,
  input  wire logic signed [17:0]    cos_a,
  input  wire logic signed [17:0]    sin_b,
  input  wire logic signed [17:0]    cos_b,
  input  wire obpc_pkg::obpc_carry_t car,
  output obpc_pkg::obpc_out_t        res
);
  import obpc_pkg::*;

  // First stage: cross terms of the two rotations and the centre offset.
  logic signed [36:0] cc_r, ss_r;
  logic signed [43:0] w0_r, h0_r, w1_r, h1_r;
  obpc_carry_t        c6_r, c7_r, c8_r;

  // Second stage: half sizes times the cross terms.
  logic signed [63:0] p_r [8];
  logic signed [63:0] p_nxt [8];
  logic signed [63:0] wa_r, ha_r, wb_r, hb_r;

  // Third stage: projections of all eight corners.
  logic signed [63:0] aw_r [8];
  logic signed [63:0] ah_r [8];
  logic signed [63:0] aw_nxt [8];
  logic signed [63:0] ah_nxt [8];

  obpc_out_t res_r;
  logic      corner;
  logic signed [63:0] limw, limh;

  always_comb begin
    p_nxt[0] = 64'($signed({1'b0, c6_r.ahw})) * 64'(cc_r);
    p_nxt[1] = 64'($signed({1'b0, c6_r.ahh})) * 64'(ss_r);
    p_nxt[2] = 64'($signed({1'b0, c6_r.ahw})) * 64'(ss_r);
    p_nxt[3] = 64'($signed({1'b0, c6_r.ahh})) * 64'(cc_r);
    p_nxt[4] = 64'($signed({1'b0, c6_r.bhw})) * 64'(cc_r);
    p_nxt[5] = 64'($signed({1'b0, c6_r.bhh})) * 64'(ss_r);
    p_nxt[6] = 64'($signed({1'b0, c6_r.bhw})) * 64'(ss_r);
    p_nxt[7] = 64'($signed({1'b0, c6_r.bhh})) * 64'(cc_r);
  end

  // Corner k takes the minus sign on the half width when bit 0 is set and on
  // the half height when bit 1 is set. For B in A the sine cross term flips.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      aw_nxt[k]   = wa_r + (k[0] ? -p_r[0] : p_r[0]) - (k[1] ? -p_r[1] : p_r[1]);
      ah_nxt[k]   = ha_r + (k[0] ? -p_r[2] : p_r[2]) + (k[1] ? -p_r[3] : p_r[3]);
      aw_nxt[k+4] = wb_r + (k[0] ? -p_r[4] : p_r[4]) + (k[1] ? -p_r[5] : p_r[5]);
      ah_nxt[k+4] = hb_r - (k[0] ? -p_r[6] : p_r[6]) + (k[1] ? -p_r[7] : p_r[7]);
    end
  end

  always_comb begin
    corner = 1'b0;
    for (int k = 0; k < 8; k++) begin
      limw = (k < 4) ? $signed({16'd0, c8_r.bhw, 32'd0}) : $signed({16'd0, c8_r.ahw, 32'd0});
      limh = (k < 4) ? $signed({16'd0, c8_r.bhh, 32'd0}) : $signed({16'd0, c8_r.ahh, 32'd0});
      if (aw_r[k] <= limw && -aw_r[k] <= limw && ah_r[k] <= limh && -ah_r[k] <= limh) begin
        corner = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cc_r <= 37'(cos_a) * 37'(cos_b) + 37'(sin_a) * 37'(sin_b);
      ss_r <= 37'(sin_a) * 37'(cos_b) - 37'(cos_a) * 37'(sin_b);
      w0_r <= 44'(44'(car.dx) * 44'(cos_b)) + 44'(44'(car.dy) * 44'(sin_b));
      h0_r <= 44'(44'(car.dy) * 44'(cos_b)) - 44'(44'(car.dx) * 44'(sin_b));
      w1_r <= 44'(44'(car.dx) * 44'(cos_a)) + 44'(44'(car.dy) * 44'(sin_a));
      h1_r <= 44'(44'(car.dy) * 44'(cos_a)) - 44'(44'(car.dx) * 44'(sin_a));
      c6_r <= car;
    end
    if (en[1]) begin
      for (int k = 0; k < 8; k++) begin
        p_r[k] <= p_nxt[k];
      end
      wa_r <= 64'(w0_r) <<< 16;
      ha_r <= 64'(h0_r) <<< 16;
      wb_r <= -(64'(w1_r) <<< 16);
      hb_r <= -(64'(h1_r) <<< 16);
      c7_r <= c6_r;
    end
    if (en[2]) begin
      for (int k = 0; k < 8; k++) begin
        aw_r[k] <= aw_nxt[k];
        ah_r[k] <= ah_nxt[k];
      end
      c8_r <= c7_r;
    end
    if (en[3]) begin
      res_r.circle_hit <= c8_r.circ;
      res_r.corner_hit <= corner;
      res_r.collided   <= c8_r.circ | corner;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

>>> rtl/oriented_box_pair_collision_unit.sv
// ----------------------------------------------------------------------------
// oriented_box_pair_collision_unit
// A request accepted at the input runs through ten register stages, input to
// output. Throughput: one request per cycle, sustained while out_stall is low,
// set by the fully pipelined sine and projection multipliers. Reset clears
// only the stage valid bits; the block holds no state between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module oriented_box_pair_collision_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire obpc_pkg::obpc_in_t in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output obpc_pkg::obpc_out_t     out_req
);
  import obpc_pkg::*;

  // Each stage moves when it is empty or when the stage after it moves, so
  // bubbles collapse and a stall at the output only backs up full stages.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Input register.
  obpc_in_t in_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      in_r <= in_req;
    end
  end

  // The circle test and the centre offsets ride alongside the sine stages.
  // Squared distance and squared radius sum are formed in the first stage
  // and compared in the second.
  obpc_carry_t car_r [1:5];
  obpc_carry_t car1_nxt;
  obpc_carry_t car2_nxt;
  logic [49:0] dsx_r, dsy_r;
  logic [33:0] rs2_r;
  logic [16:0] rsum;

  always_comb begin
    car1_nxt.dx   = 25'(in_r.a_pos_x) - 25'(in_r.b_pos_x);
    car1_nxt.dy   = 25'(in_r.a_pos_y) - 25'(in_r.b_pos_y);
    car1_nxt.ahw  = in_r.a_half_w;
    car1_nxt.ahh  = in_r.a_half_h;
    car1_nxt.bhw  = in_r.b_half_w;
    car1_nxt.bhh  = in_r.b_half_h;
    car1_nxt.circ = 1'b0;
    rsum          = 17'(in_r.a_radius) + 17'(in_r.b_radius);
  end

  always_comb begin
    car2_nxt      = car_r[1];
    car2_nxt.circ = (51'(dsx_r) + 51'(dsy_r)) <= 51'(rs2_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      car_r[1] <= car1_nxt;
      dsx_r    <= 50'(50'(car1_nxt.dx) * 50'(car1_nxt.dx));
      dsy_r    <= 50'(50'(car1_nxt.dy) * 50'(car1_nxt.dy));
      rs2_r    <= 34'(rsum) * 34'(rsum);
    end
    if (en[2]) begin
      car_r[2] <= car2_nxt;
    end
    for (int i = 3; i <= 5; i++) begin
      if (en[i]) begin
        car_r[i] <= car_r[i-1];
      end
    end
  end

  // Four sine pipelines: sine and cosine of each body's angle.
  logic signed [17:0] sin_a, cos_a, sin_b, cos_b;

  obpc_sine u_sin_a (.clk(clk), .en(en[5:1]), .ang(in_r.a_angle), .cos_sel(1'b0), .s(sin_a));
  obpc_sine u_cos_a (.clk(clk), .en(en[5:1]), .ang(in_r.a_angle), .cos_sel(1'b1), .s(cos_a));
  obpc_sine u_sin_b (.clk(clk), .en(en[5:1]), .ang(in_r.b_angle), .cos_sel(1'b0), .s(sin_b));
  obpc_sine u_cos_b (.clk(clk), .en(en[5:1]), .ang(in_r.b_angle), .cos_sel(1'b1), .s(cos_b));

  // Corner projections and the final output register.
  obpc_geom u_geom (
    .clk   (clk),
    .en    (en[9:6]),
    .sin_a (sin_a),
    .cos_a (cos_a),
    .sin_b (sin_b),
    .cos_b (cos_b),
    .car   (car_r[5]),
    .res   (out_req)
  );

  // The input side stalls only when every stage holds a request.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with an empty stage");

  // A free output never stalls the input.
  a_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // A stalled result is not dropped.
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result lost");

endmodule

`default_nettype wire
